// ===== sv/twb_pkg.sv =====
// Shared constants, beat types and control types for the transaction write buffer.
`default_nettype none

package twb_pkg;

	localparam int DEPTH     = 32;
	localparam int ADDR_BITS = 32;
	localparam int DATA_W    = 32;
	localparam int IN_ADDR_W = 32;
	localparam int OPC_W     = 3;
	localparam int ENTRY_W   = 6;
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int KEY_W     = (ADDR_BITS < IN_ADDR_W) ? ADDR_BITS : IN_ADDR_W;

	typedef enum logic [OPC_W-1:0] {
		OP_INSERT = 3'd0,
		OP_UPDATE = 3'd1,
		OP_LOOKUP = 3'd2,
		OP_CLEAR  = 3'd3,
		OP_DRAIN  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LOOKUP,
		ST_DRAIN
	} state_t;

	// which fields a result beat carries
	typedef enum logic [1:0] {
		RK_BASIC,
		RK_LOOKUP,
		RK_DRAIN
	} rk_t;

	typedef struct packed {
		logic [OPC_W-1:0]     opcode;
		logic [IN_ADDR_W-1:0] address;
		logic signed [DATA_W-1:0] data_value;
		logic                 wide_type;
	} in_beat_t;

	typedef struct packed {
		logic                 status;
		logic                 found;
		logic                 valid_res;
		logic [IN_ADDR_W-1:0] out_address;
		logic signed [DATA_W-1:0] out_value;
		logic                 out_type;
		logic [ENTRY_W-1:0]   entry_count;
		logic                 last;
	} out_beat_t;

	typedef struct packed {
		logic accept;
		logic append;
		logic write_hit;
		logic clear;
		logic rd_lookup;
		logic drain_start;
		logic drain_step;
		logic emit;
		rk_t  kind;
		logic full_status;
		logic found;
		logic last;
	} dp_cmd_t;

	typedef struct packed {
		op_t  op;
		logic hit;
		logic full;
		logic empty;
		logic last_entry;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== sv/twb_dp.sv =====
// Datapath: address match array, entry memories, fill count and result register.
`default_nettype none

module twb_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire twb_pkg::in_beat_t   request,
	input  wire twb_pkg::dp_cmd_t    cmd,
	output twb_pkg::dp_status_t      st,
	output logic                     done,
	output twb_pkg::out_beat_t       result
);
	import twb_pkg::*;

	logic [KEY_W-1:0]  key_in;
	logic [KEY_W-1:0]  key_q;
	logic [DATA_W-1:0] value_q;
	logic              type_q;
	logic [OPC_W-1:0]  opc_q;

	logic [KEY_W-1:0]  cam_q [DEPTH];
	logic [DEPTH-1:0]  match_s1;
	logic              hit;
	logic [IDX_W-1:0]  hit_idx;

	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  fill_d;
	logic [IDX_W-1:0]  drain_idx_q;

	logic [DATA_W-1:0] val_mem  [DEPTH];
	logic [KEY_W:0]    meta_mem [DEPTH];
	logic [DATA_W-1:0] rd_val_q;
	logic [KEY_W:0]    rd_meta_q;
	logic [IDX_W-1:0]  wr_idx;
	logic [IDX_W-1:0]  rd_idx;
	logic              rd_en;

	out_beat_t         res_d;
	out_beat_t         result_q;
	logic              done_q;

	assign key_in = request.address[KEY_W-1:0];

	// latch the command beat and compare its key against every held entry
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			key_q   <= key_in;
			value_q <= request.data_value;
			type_q  <= request.wide_type;
			opc_q   <= request.opcode;
			for (int i = 0; i < DEPTH; i++) begin
				match_s1[i] <= (CNT_W'(i) < fill_q) && (cam_q[i] == key_in);
			end
		end
	end

	// oldest match wins
	always_comb begin
		hit     = |match_s1;
		hit_idx = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (match_s1[i]) begin
				hit_idx = IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.append) begin
			cam_q[fill_q[IDX_W-1:0]] <= key_q;
		end
	end

	assign fill_d = cmd.clear  ? '0 :
	                cmd.append ? fill_q + CNT_W'(1) : fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			drain_idx_q <= '0;
		end else begin
			fill_q <= fill_d;
			if (cmd.drain_start) begin
				drain_idx_q <= '0;
			end else if (cmd.drain_step) begin
				drain_idx_q <= drain_idx_q + IDX_W'(1);
			end
		end
	end

	// entry memories: one write port, one registered read port each
	assign wr_idx = cmd.append ? fill_q[IDX_W-1:0] : hit_idx;
	assign rd_idx = cmd.rd_lookup   ? hit_idx :
	                cmd.drain_start ? '0 : drain_idx_q + IDX_W'(1);
	assign rd_en  = cmd.rd_lookup | cmd.drain_start | cmd.drain_step;

	always_ff @(posedge clk) begin
		if (cmd.append || cmd.write_hit) begin
			val_mem[wr_idx] <= value_q;
		end
		if (cmd.append) begin
			meta_mem[wr_idx] <= {key_q, type_q};
		end
		if (rd_en) begin
			rd_val_q  <= val_mem[rd_idx];
			rd_meta_q <= meta_mem[rd_idx];
		end
	end

	assign st.op         = op_t'(opc_q);
	assign st.hit        = hit;
	assign st.full       = (fill_q == CNT_W'(DEPTH));
	assign st.empty      = (fill_q == '0);
	assign st.last_entry = ((CNT_W'(drain_idx_q) + CNT_W'(1)) == fill_q);

	always_comb begin
		res_d             = '0;
		res_d.entry_count = ENTRY_W'(fill_d);
		case (cmd.kind)
			RK_BASIC: begin
				res_d.status = cmd.full_status;
				res_d.found  = cmd.found;
				res_d.last   = 1'b1;
			end
			RK_LOOKUP: begin
				res_d.found     = 1'b1;
				res_d.out_value = rd_val_q;
				res_d.out_type  = rd_meta_q[0];
				res_d.last      = 1'b1;
			end
			RK_DRAIN: begin
				res_d.valid_res   = 1'b1;
				res_d.out_address = IN_ADDR_W'(rd_meta_q[KEY_W:1]);
				res_d.out_value   = rd_val_q;
				res_d.out_type    = rd_meta_q[0];
				res_d.last        = cmd.last;
			end
			default: begin
				res_d.last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q <= res_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

// ===== sv/twb_ctrl.sv =====
// Controller: sequences one command beat through match, memory access and result beats.
`default_nettype none

module twb_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire twb_pkg::dp_status_t  st,
	output twb_pkg::dp_cmd_t          cmd,
	output logic                      busy
);
	import twb_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (st.op)
					OP_LOOKUP: state_d = st.hit   ? ST_LOOKUP : ST_IDLE;
					OP_DRAIN:  state_d = st.empty ? ST_IDLE   : ST_DRAIN;
					default:   state_d = ST_IDLE;
				endcase
			end
			ST_LOOKUP: state_d = ST_IDLE;
			ST_DRAIN: begin
				if (st.last_entry) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.kind = RK_BASIC;
		case (state_q)
			ST_IDLE: begin
				cmd.accept = start;
			end
			ST_EXEC: begin
				cmd.emit = 1'b1;
				case (st.op)
					OP_INSERT: begin
						cmd.full_status = st.full;
						cmd.append      = !st.full;
					end
					OP_UPDATE: begin
						if (st.hit) begin
							cmd.write_hit = 1'b1;
							cmd.found     = 1'b1;
						end else begin
							cmd.full_status = st.full;
							cmd.append      = !st.full;
						end
					end
					OP_LOOKUP: begin
						cmd.rd_lookup = st.hit;
						cmd.emit      = !st.hit;
					end
					OP_CLEAR: begin
						cmd.clear = 1'b1;
					end
					OP_DRAIN: begin
						cmd.drain_start = !st.empty;
						cmd.emit        = st.empty;
					end
					default: begin
						cmd.emit = 1'b1;
					end
				endcase
			end
			ST_LOOKUP: begin
				cmd.emit = 1'b1;
				cmd.kind = RK_LOOKUP;
			end
			ST_DRAIN: begin
				cmd.emit       = 1'b1;
				cmd.kind       = RK_DRAIN;
				cmd.last       = st.last_entry;
				cmd.drain_step = !st.last_entry;
			end
			default: begin
				cmd.accept = 1'b0;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

`default_nettype wire

// ===== sv/transaction_write_buffer_top.sv =====
// Top level of the transaction write buffer (redo log of address, value, type).
//
//  channel   handshake        payload            direction
//  command   start / busy     request (in_beat)  in: taken when start & !busy
//  result    done             result (out_beat)  out: one beat per cycle done is high
//
// Sequence: a command beat is matched against all held entries in the accept
// cycle, then execute. Insert, update, clear, lookup miss and empty drain:
// busy in execute only, result beat the cycle after. Lookup hit: busy in
// execute and lookup (entry memory read). Drain of N entries: busy in
// execute and drain; N back-to-back result beats, the final one with last set.
// Reset clears the fill count and control; entry storage is not cleared.
// The receiver cannot stall; a new command may be taken while a result shows.
`default_nettype none

module transaction_write_buffer_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire twb_pkg::in_beat_t  request,
	output logic                    done,
	output twb_pkg::out_beat_t      result
);
	import twb_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t st;

	// controller: walks each command through execute, memory read and drain
	twb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy)
	);

	// datapath: key compare array, value/meta memories, result register
	twb_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.st      (st),
		.done    (done),
		.result  (result)
	);

	// an accepted beat always starts work
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("command beat accepted but block not busy");

	// a drain stream has no gaps until its last beat
	a_drain_contig: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.last) |=> done)
		else $error("gap inside a drain stream");

	// going idle coincides with the final result beat of the command
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (done && result.last))
		else $error("block went idle without a final result beat");

endmodule

`default_nettype wire
